@@ hw/rtl/tatd_pkg.sv @@
package tatd_pkg;

    // field widths
    localparam int ACCEL_W    = 16;
    localparam int COS_W      = 16;
    localparam int STABLE_W   = 8;
    localparam int OVER_RUN_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RUN_BITS_DEF    = 16;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE = 1'd1;
    localparam logic [COS_W-1:0]     COS_RESET    = 16'd28377;
    localparam logic [STABLE_W-1:0]  STABLE_RESET = 8'd10;

    localparam logic [OVER_RUN_W-1:0] OVER_RUN_MAX = '1;

    // shared multiplier and accumulator widths
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DOT_W   = 34;
    localparam int SQ_W    = 32;
    localparam int WIDE_W  = 64;
    localparam int CMP_W   = 96;
    // dot^2 * 2^30 against c^2 * |v|^2 * |ref|^2
    localparam int Q2_SHIFT = 30;

    typedef struct packed {
        logic                      start;
        logic signed [ACCEL_W-1:0] x;
        logic signed [ACCEL_W-1:0] y;
        logic signed [ACCEL_W-1:0] z;
        logic signed [ACCEL_W-1:0] rx;
        logic signed [ACCEL_W-1:0] ry;
        logic signed [ACCEL_W-1:0] rz;
        logic [COS_W-1:0]          cos_thr;
    } angle_req_t;

    typedef struct packed {
        logic done;
        logic over;
    } angle_status_t;

endpackage

@@ hw/rtl/tatd_mul.sv @@
module tatd_mul (
    input  logic                               aclk,
    input  logic signed [tatd_pkg::MUL_W-1:0]  a,
    input  logic signed [tatd_pkg::MUL_W-1:0]  b,
    output logic signed [tatd_pkg::PROD_W-1:0] p
);
    import tatd_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/tatd_angle.sv @@
module tatd_angle (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tatd_pkg::angle_req_t    req,
    output tatd_pkg::angle_status_t status
);
    import tatd_pkg::*;

    localparam int STEP_W = 4;

    // product issued at each step
    localparam logic [STEP_W-1:0] S_XR  = 4'd0;
    localparam logic [STEP_W-1:0] S_YR  = 4'd1;
    localparam logic [STEP_W-1:0] S_ZR  = 4'd2;
    localparam logic [STEP_W-1:0] S_XX  = 4'd3;
    localparam logic [STEP_W-1:0] S_YY  = 4'd4;
    localparam logic [STEP_W-1:0] S_ZZ  = 4'd5;
    localparam logic [STEP_W-1:0] S_RXX = 4'd6;
    localparam logic [STEP_W-1:0] S_RYY = 4'd7;
    localparam logic [STEP_W-1:0] S_RZZ = 4'd8;
    localparam logic [STEP_W-1:0] S_CC  = 4'd9;
    localparam logic [STEP_W-1:0] S_VR  = 4'd10;
    localparam logic [STEP_W-1:0] S_DD  = 4'd11;
    localparam logic [STEP_W-1:0] S_CLO = 4'd12;
    localparam logic [STEP_W-1:0] S_CHI = 4'd13;
    localparam logic [STEP_W-1:0] S_CMP = 4'd15;

    logic                     busy_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     pv_reg;
    logic [STEP_W-1:0]        pk_reg;
    logic signed [DOT_W-1:0]  acc_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic [SQ_W-1:0]          vv_reg;
    logic [SQ_W-1:0]          rr_reg;
    logic [SQ_W-1:0]          c2_reg;
    logic [WIDE_W-1:0]        vr_reg;
    logic [WIDE_W-1:0]        d2_reg;
    logic [CMP_W-1:0]         rhs_reg;

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [DOT_W-1:0]  acc_base;
    logic signed [DOT_W-1:0]  acc_sum;
    logic signed [MUL_W-1:0]  dot_mag;
    logic [CMP_W-1:0]         lhs;

    tatd_mul u_mul (
        .aclk (aclk),
        .a    (op_a),
        .b    (op_b),
        .p    (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            pv_reg   <= 1'b0;
        end else begin
            pv_reg <= busy_reg && (step_reg <= S_CHI);
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == S_CMP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // only read when the dot product is non-negative
    assign dot_mag = $signed({1'b0, dot_reg[SQ_W-1:0]});

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            S_XR:  begin op_a = MUL_W'(req.x);  op_b = MUL_W'(req.rx); end
            S_YR:  begin op_a = MUL_W'(req.y);  op_b = MUL_W'(req.ry); end
            S_ZR:  begin op_a = MUL_W'(req.z);  op_b = MUL_W'(req.rz); end
            S_XX:  begin op_a = MUL_W'(req.x);  op_b = MUL_W'(req.x);  end
            S_YY:  begin op_a = MUL_W'(req.y);  op_b = MUL_W'(req.y);  end
            S_ZZ:  begin op_a = MUL_W'(req.z);  op_b = MUL_W'(req.z);  end
            S_RXX: begin op_a = MUL_W'(req.rx); op_b = MUL_W'(req.rx); end
            S_RYY: begin op_a = MUL_W'(req.ry); op_b = MUL_W'(req.ry); end
            S_RZZ: begin op_a = MUL_W'(req.rz); op_b = MUL_W'(req.rz); end
            S_CC: begin
                op_a = $signed({{(MUL_W-COS_W){1'b0}}, req.cos_thr});
                op_b = $signed({{(MUL_W-COS_W){1'b0}}, req.cos_thr});
            end
            S_VR: begin
                op_a = $signed({1'b0, vv_reg});
                op_b = $signed({1'b0, rr_reg});
            end
            S_DD: begin
                op_a = dot_mag;
                op_b = dot_mag;
            end
            S_CLO: begin
                op_a = $signed({1'b0, c2_reg});
                op_b = $signed({1'b0, vr_reg[SQ_W-1:0]});
            end
            S_CHI: begin
                op_a = $signed({1'b0, c2_reg});
                op_b = $signed({1'b0, vr_reg[WIDE_W-1:SQ_W]});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // three-term sums restart on the first product of each group
    assign acc_base = (pk_reg == S_XR || pk_reg == S_XX || pk_reg == S_RXX) ? '0 : acc_reg;
    assign acc_sum  = acc_base + prod[DOT_W-1:0];

    always_ff @(posedge aclk) begin
        pk_reg <= step_reg;
        if (pv_reg) begin
            case (pk_reg)
                S_XR, S_YR, S_XX, S_YY, S_RXX, S_RYY: acc_reg <= acc_sum;
                S_ZR:  dot_reg <= acc_sum;
                S_ZZ:  vv_reg  <= acc_sum[SQ_W-1:0];
                S_RZZ: rr_reg  <= acc_sum[SQ_W-1:0];
                S_CC:  c2_reg  <= prod[SQ_W-1:0];
                S_VR:  vr_reg  <= prod[WIDE_W-1:0];
                S_DD:  d2_reg  <= prod[WIDE_W-1:0];
                S_CLO: rhs_reg <= {{(CMP_W-WIDE_W){1'b0}}, prod[WIDE_W-1:0]};
                S_CHI: rhs_reg[CMP_W-1:SQ_W] <= rhs_reg[CMP_W-1:SQ_W] + prod[WIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign lhs = {{(CMP_W-WIDE_W-Q2_SHIFT){1'b0}}, d2_reg, {Q2_SHIFT{1'b0}}};

    always_comb begin
        status.done = busy_reg && (step_reg == S_CMP);
        if (vv_reg == '0 || rr_reg == '0) begin
            status.over = 1'b0;
        end else if (dot_reg[DOT_W-1]) begin
            status.over = 1'b1;
        end else begin
            status.over = lhs < rhs_reg;
        end
    end

endmodule

@@ hw/rtl/tilt_angle_threshold_detector.sv @@
// Tilt angle detector for 3-axis accelerometer samples. After reset or a restart
// request (op = 1) the block calibrates: each sample equal to the previous one
// adds to a match count that a mismatch does not clear, and when the count reaches
// stable_needed the sample becomes the reference vector. From then on each sample
// is flagged over-angle when the angle between it and the reference exceeds the
// limit whose cosine is cos_threshold (unsigned Q1.15), tested exactly with
// integer squares; a zero vector is never over-angle, and over_run counts
// consecutive over-angle samples with saturation. One request is in work at a
// time. A restart or calibration request passes from acceptance through the
// finish state to the result register; a tilt test first runs its 14 products,
// which go one per cycle through a single shared 33x33 multiplier, and the
// final compare. s_ready returns at the edge that loads the result; a result
// still waiting for m_ready holds the next load back. Configuration writes are
// taken in any cycle.
module tilt_angle_threshold_detector #(
    parameter int SAMPLE_BITS = tatd_pkg::SAMPLE_BITS_DEF,
    parameter int RUN_BITS    = tatd_pkg::RUN_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_op,
    input  logic signed [tatd_pkg::ACCEL_W-1:0]   s_accel_x,
    input  logic signed [tatd_pkg::ACCEL_W-1:0]   s_accel_y,
    input  logic signed [tatd_pkg::ACCEL_W-1:0]   s_accel_z,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_calibrated,
    output logic                                  m_over_angle,
    output logic [tatd_pkg::OVER_RUN_W-1:0]       m_over_run,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tatd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tatd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tatd_pkg::*;

    localparam int SH         = ACCEL_W - SAMPLE_BITS;
    localparam int RUN_WIDE_W = (RUN_BITS > OVER_RUN_W) ? RUN_BITS : OVER_RUN_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TEST   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                state_reg;
    logic [COS_W-1:0]          cos_reg;
    logic [STABLE_W-1:0]       stable_reg;
    logic signed [ACCEL_W-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic signed [ACCEL_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [STABLE_W-1:0]       match_reg;
    logic                      have_ref_reg;
    logic [RUN_BITS-1:0]       run_reg;

    logic                      op_reg;
    logic signed [ACCEL_W-1:0] x_reg, y_reg, z_reg;
    logic                      over_reg;

    logic                      m_valid_reg;
    logic                      cal_out_reg;
    logic                      over_out_reg;
    logic [OVER_RUN_W-1:0]     run_out_reg;

    logic signed [ACCEL_W-1:0] x_sx, y_sx, z_sx;
    logic                      accept;
    logic                      finish;
    logic                      same;
    logic [STABLE_W-1:0]       match_next;
    logic                      latch;
    logic [RUN_BITS-1:0]       run_test;
    logic [RUN_BITS-1:0]       run_next;
    logic [RUN_WIDE_W-1:0]     run_wide;
    logic                      cal_next;
    logic                      over_next;

    angle_req_t                areq;
    angle_status_t             astat;

    assign x_sx = $signed(s_accel_x << SH) >>> SH;
    assign y_sx = $signed(s_accel_y << SH) >>> SH;
    assign z_sx = $signed(s_accel_z << SH) >>> SH;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign finish    = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    assign areq.start   = accept && !s_op && have_ref_reg;
    assign areq.x       = x_reg;
    assign areq.y       = y_reg;
    assign areq.z       = z_reg;
    assign areq.rx      = ref_x_reg;
    assign areq.ry      = ref_y_reg;
    assign areq.rz      = ref_z_reg;
    assign areq.cos_thr = cos_reg;

    tatd_angle u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .status  (astat)
    );

    always_comb begin
        same       = (x_reg == prev_x_reg) && (y_reg == prev_y_reg) && (z_reg == prev_z_reg);
        match_next = (same && match_reg != '1) ? match_reg + 1'b1 : match_reg;
        latch      = (match_next >= stable_reg);
        if (over_reg) begin
            run_test = (run_reg != '1) ? run_reg + 1'b1 : run_reg;
        end else begin
            run_test = '0;
        end

        if (op_reg) begin
            run_next  = '0;
            cal_next  = 1'b0;
            over_next = 1'b0;
        end else if (!have_ref_reg) begin
            run_next  = latch ? '0 : run_reg;
            cal_next  = latch;
            over_next = 1'b0;
        end else begin
            run_next  = run_test;
            cal_next  = 1'b1;
            over_next = over_reg;
        end
        run_wide = RUN_WIDE_W'(run_next);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= COS_RESET;
            stable_reg <= STABLE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COS:    cos_reg    <= cfg_data[COS_W-1:0];
                CFG_STABLE: stable_reg <= cfg_data[STABLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= s_op;
            x_reg  <= x_sx;
            y_reg  <= y_sx;
            z_reg  <= z_sx;
        end
        if (astat.done) begin
            over_reg <= astat.over;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ref_x_reg    <= '0;
            ref_y_reg    <= '0;
            ref_z_reg    <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_z_reg   <= '0;
            match_reg    <= '0;
            have_ref_reg <= 1'b0;
            run_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= (!s_op && have_ref_reg) ? ST_TEST : ST_FINISH;
                    end
                end
                ST_TEST: begin
                    if (astat.done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (finish) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (finish) begin
                run_reg <= run_next;
                if (op_reg) begin
                    prev_x_reg   <= '0;
                    prev_y_reg   <= '0;
                    prev_z_reg   <= '0;
                    match_reg    <= '0;
                    have_ref_reg <= 1'b0;
                end else if (!have_ref_reg) begin
                    prev_x_reg <= x_reg;
                    prev_y_reg <= y_reg;
                    prev_z_reg <= z_reg;
                    match_reg  <= match_next;
                    if (latch) begin
                        ref_x_reg    <= x_reg;
                        ref_y_reg    <= y_reg;
                        ref_z_reg    <= z_reg;
                        have_ref_reg <= 1'b1;
                    end
                end
            end

            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (finish) begin
            cal_out_reg  <= cal_next;
            over_out_reg <= over_next;
            if (run_wide > RUN_WIDE_W'(OVER_RUN_MAX)) begin
                run_out_reg <= OVER_RUN_MAX;
            end else begin
                run_out_reg <= run_wide[OVER_RUN_W-1:0];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_calibrated = cal_out_reg;
    assign m_over_angle = over_out_reg;
    assign m_over_run   = run_out_reg;

endmodule
